/* design/set_assoc_lru_cache_tag_model_top_defines.svh */
// Assertion macros for the cache tag model controller (salc_ctrl).
`ifndef SET_ASSOC_LRU_CACHE_TAG_MODEL_TOP_DEFINES_SVH
`define SET_ASSOC_LRU_CACHE_TAG_MODEL_TOP_DEFINES_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define SALC_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("salc assertion failed");

// Checks that the consequent holds in the cycle after the antecedent.
`define SALC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("salc assertion failed");

`endif

/* design/salc_pkg.sv */
package salc_pkg;

    localparam int P_LOG_MAX_SETS = 10;
    localparam int P_MAX_WAYS     = 8;
    localparam int P_COUNT_WIDTH  = 48;

    typedef struct packed {
        logic        mode;
        logic [31:0] address;
    } t_in;

    typedef struct packed {
        logic        hit;
        logic [2:0]  way;
        logic [47:0] read_requests;
        logic [47:0] write_requests;
        logic [47:0] read_hits;
        logic [47:0] write_hits;
    } t_out;

    typedef struct packed {
        logic clr_step;
        logic load_in;
        logic hash_a;
        logic hash_b;
        logic addr;
        logic rd;
        logic commit;
    } t_cmd;

    typedef struct packed {
        logic clr_last;
        logic out_free;
    } t_sts;

    typedef struct packed {
        logic [1:0] index_mode;
        logic [3:0] log_rows;
        logic [3:0] log_block;
        logic [3:0] ways_in_use;
        logic [4:0] log_page;
        logic [5:0] log_phys_mem;
    } t_cfg;

endpackage

/* design/salc_ctrl.sv */
`include "set_assoc_lru_cache_tag_model_top_defines.svh"

module salc_ctrl
    import salc_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  t_sts i_sts,
    output logic o_in_stall,
    output t_cmd o_cmd
);

    localparam logic [2:0] ST_CLR  = 3'd0;
    localparam logic [2:0] ST_IDLE = 3'd1;
    localparam logic [2:0] ST_HA   = 3'd2;
    localparam logic [2:0] ST_HB   = 3'd3;
    localparam logic [2:0] ST_AD   = 3'd4;
    localparam logic [2:0] ST_RD   = 3'd5;
    localparam logic [2:0] ST_LK   = 3'd6;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_CLR: begin
                o_cmd.clr_step = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state = ST_HA;
                end
            end
            ST_HA: begin
                o_cmd.hash_a = 1'b1;
                n_state = ST_HB;
            end
            ST_HB: begin
                o_cmd.hash_b = 1'b1;
                n_state = ST_AD;
            end
            ST_AD: begin
                o_cmd.addr = 1'b1;
                n_state = ST_RD;
            end
            ST_RD: begin
                o_cmd.rd = 1'b1;
                n_state = ST_LK;
            end
            ST_LK: begin
                if (i_sts.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_in_stall = (r_state != ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLR;
        end else begin
            r_state <= n_state;
        end
    end

    `SALC_ASSERT_NEXT(a_commit_idle, r_state == ST_LK && i_sts.out_free, r_state == ST_IDLE)
    `SALC_ASSERT_NEXT(a_load_hash, o_cmd.load_in, r_state == ST_HA)
    `SALC_ASSERT_NOW(a_commit_free, o_cmd.commit, i_sts.out_free)

endmodule

/* design/salc_dp.sv */
module salc_dp
    import salc_pkg::*;
#(
    parameter int LOG_MAX_SETS = P_LOG_MAX_SETS,
    parameter int MAX_WAYS     = P_MAX_WAYS,
    parameter int COUNT_WIDTH  = P_COUNT_WIDTH
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_cmd i_cmd,
    output t_sts o_sts,
    input  t_cfg i_cfg,
    input  t_in  i_in_data,
    input  logic i_out_stall,
    output logic o_out_valid,
    output t_out o_out_data
);

    localparam int NSETS = 1 << LOG_MAX_SETS;
    localparam int LW    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int NP    = 1 << $clog2(MAX_WAYS);

    logic [MAX_WAYS-1:0][29:0] m_tag   [NSETS];
    logic [MAX_WAYS-1:0][31:0] m_stamp [NSETS];
    logic [MAX_WAYS-1:0]       m_valid [NSETS];

    logic                      r_mode;
    logic [31:0]               r_vaddr;
    logic [31:0]               r_key;
    logic [31:0]               r_hash;
    logic [29:0]               r_tag;
    logic [LOG_MAX_SETS-1:0]   r_set;
    logic [LOG_MAX_SETS-1:0]   r_clr_addr;
    logic [MAX_WAYS-1:0][29:0] r_rd_tag;
    logic [MAX_WAYS-1:0][31:0] r_rd_stamp;
    logic [MAX_WAYS-1:0]       r_rd_valid;
    logic [31:0]               r_stamp_ctr;
    logic [COUNT_WIDTH-1:0]    r_rd_cnt;
    logic [COUNT_WIDTH-1:0]    r_wr_cnt;
    logic [COUNT_WIDTH-1:0]    r_rh_cnt;
    logic [COUNT_WIDTH-1:0]    r_wh_cnt;
    logic                      r_out_valid;
    t_out                      r_out;

    logic [31:0] ha_k, ha_k1, ha_k2, ha_k3;
    logic [31:0] hb_k4, hb_k5, hb_k6;

    always_comb begin
        ha_k  = r_vaddr >> i_cfg.log_page;
        ha_k1 = ~ha_k + (ha_k << 15);
        ha_k2 = ha_k1 ^ 32'($signed(ha_k1) >>> 12);
        ha_k3 = ha_k2 + (ha_k2 << 2);
        hb_k4 = r_key ^ 32'($signed(r_key) >>> 4);
        hb_k5 = hb_k4 + (hb_k4 << 3) + (hb_k4 << 11);
        hb_k6 = hb_k5 ^ 32'($signed(hb_k5) >>> 16);
    end

    logic [5:0]              pbits;
    logic [63:0]             pa64;
    logic [31:0]             ptag, vtag, tag32, set32;
    logic [4:0]              shift;
    logic [4:0]              rows;
    logic [31:0]             set_mask;
    logic [LOG_MAX_SETS-1:0] n_set;

    always_comb begin
        pbits = (i_cfg.log_phys_mem > {1'b0, i_cfg.log_page})
              ? (i_cfg.log_phys_mem - {1'b0, i_cfg.log_page}) : 6'd1;
        if (pbits > 6'd32) begin
            pbits = 6'd32;
        end
        pa64 = (({32'd0, r_hash} & ((64'd1 << pbits) - 64'd1)) << i_cfg.log_page)
             | ({32'd0, r_vaddr} & ((64'd1 << i_cfg.log_page) - 64'd1));
        shift = 5'd2 + {1'b0, i_cfg.log_block};
        ptag  = pa64[31:0] >> shift;
        vtag  = r_vaddr >> shift;
        case (i_cfg.index_mode)
            2'd0: begin
                tag32 = ptag;
                set32 = ptag;
            end
            2'd1: begin
                tag32 = ptag;
                set32 = vtag;
            end
            default: begin
                tag32 = vtag;
                set32 = vtag;
            end
        endcase
        rows = ({1'b0, i_cfg.log_rows} > 5'(LOG_MAX_SETS))
             ? 5'(LOG_MAX_SETS) : {1'b0, i_cfg.log_rows};
        set_mask = (32'd1 << rows) - 32'd1;
        n_set = set32[LOG_MAX_SETS-1:0] & set_mask[LOG_MAX_SETS-1:0];
    end

    logic [4:0]    wu;
    logic          hit;
    logic [LW-1:0] hit_way;
    logic [31:0]   lt_st [2*NP];
    logic [LW-1:0] lt_ix [2*NP];
    logic          lt_ok [2*NP];
    logic [LW-1:0] way;

    always_comb begin
        wu = (i_cfg.ways_in_use == 4'd0) ? 5'd1
           : (({1'b0, i_cfg.ways_in_use} > 5'(MAX_WAYS)) ? 5'(MAX_WAYS)
           : {1'b0, i_cfg.ways_in_use});
        hit     = 1'b0;
        hit_way = '0;
        for (int w = MAX_WAYS - 1; w >= 0; w--) begin
            if (5'(w) < wu && r_rd_valid[w] && r_rd_tag[w] == r_tag) begin
                hit     = 1'b1;
                hit_way = LW'(w);
            end
        end
        for (int i = 0; i < 2 * NP; i++) begin
            lt_st[i] = '0;
            lt_ix[i] = '0;
            lt_ok[i] = 1'b0;
        end
        for (int i = 0; i < NP; i++) begin
            if (i < MAX_WAYS) begin
                lt_st[NP+i] = r_rd_stamp[i];
                lt_ix[NP+i] = LW'(i);
                lt_ok[NP+i] = (i == 0) || (5'(i) < wu);
            end
        end
        for (int n = NP - 1; n >= 1; n--) begin
            if (lt_ok[2*n+1] && (!lt_ok[2*n] || lt_st[2*n+1] < lt_st[2*n])) begin
                lt_st[n] = lt_st[2*n+1];
                lt_ix[n] = lt_ix[2*n+1];
                lt_ok[n] = 1'b1;
            end else begin
                lt_st[n] = lt_st[2*n];
                lt_ix[n] = lt_ix[2*n];
                lt_ok[n] = lt_ok[2*n];
            end
        end
        way = hit ? hit_way : lt_ix[1];
    end

    logic [31:0]               n_stamp_ctr;
    logic [MAX_WAYS-1:0][29:0] n_tag_row;
    logic [MAX_WAYS-1:0][31:0] n_stamp_row;
    logic [MAX_WAYS-1:0]       n_valid_row;
    logic [COUNT_WIDTH-1:0]    n_rd_cnt, n_wr_cnt, n_rh_cnt, n_wh_cnt;

    always_comb begin
        n_stamp_ctr = r_stamp_ctr + 32'd1;
        n_tag_row   = r_rd_tag;
        n_stamp_row = r_rd_stamp;
        n_valid_row = r_rd_valid;
        if (!hit) begin
            n_tag_row[way]   = r_tag;
            n_valid_row[way] = 1'b1;
        end
        n_stamp_row[way] = n_stamp_ctr;
        n_rd_cnt = r_rd_cnt + COUNT_WIDTH'(!r_mode);
        n_wr_cnt = r_wr_cnt + COUNT_WIDTH'(r_mode);
        n_rh_cnt = r_rh_cnt + COUNT_WIDTH'(!r_mode && hit);
        n_wh_cnt = r_wh_cnt + COUNT_WIDTH'(r_mode && hit);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_step) begin
            m_valid[r_clr_addr] <= '0;
            m_stamp[r_clr_addr] <= '0;
        end else if (i_cmd.commit) begin
            m_valid[r_set] <= n_valid_row;
            m_stamp[r_set] <= n_stamp_row;
            m_tag[r_set]   <= n_tag_row;
        end
        if (i_cmd.rd) begin
            r_rd_tag   <= m_tag[r_set];
            r_rd_stamp <= m_stamp[r_set];
            r_rd_valid <= m_valid[r_set];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_mode  <= i_in_data.mode;
            r_vaddr <= {i_in_data.address[31:2], 2'b00};
        end
        if (i_cmd.hash_a) begin
            r_key <= ha_k3;
        end
        if (i_cmd.hash_b) begin
            r_hash <= hb_k6;
        end
        if (i_cmd.addr) begin
            r_tag <= tag32[29:0];
            r_set <= n_set;
        end
        if (i_cmd.commit) begin
            r_out.hit            <= hit;
            r_out.way            <= 3'(way);
            r_out.read_requests  <= 48'(64'(n_rd_cnt));
            r_out.write_requests <= 48'(64'(n_wr_cnt));
            r_out.read_hits      <= 48'(64'(n_rh_cnt));
            r_out.write_hits     <= 48'(64'(n_wh_cnt));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr  <= '0;
            r_stamp_ctr <= '0;
            r_rd_cnt    <= '0;
            r_wr_cnt    <= '0;
            r_rh_cnt    <= '0;
            r_wh_cnt    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.clr_step) begin
                r_clr_addr <= r_clr_addr + LOG_MAX_SETS'(1);
            end
            if (i_cmd.commit) begin
                r_stamp_ctr <= n_stamp_ctr;
                r_rd_cnt    <= n_rd_cnt;
                r_wr_cnt    <= n_wr_cnt;
                r_rh_cnt    <= n_rh_cnt;
                r_wh_cnt    <= n_wh_cnt;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_sts.clr_last = &r_clr_addr;
    assign o_sts.out_free = !r_out_valid || !i_out_stall;
    assign o_out_valid    = r_out_valid;
    assign o_out_data     = r_out;

endmodule

/* design/set_assoc_lru_cache_tag_model_top.sv */
// Set-associative LRU cache tag model.
// Input channel: i_in_valid / o_in_stall carry one access beat (mode, address).
// Output channel: o_out_valid / i_out_stall carry one result beat per access:
// hit flag, way, and the read/write request and hit counters after it.
// An access passes through two hash states, an address state, a tag/stamp
// memory read and a lookup state that writes the set row back; the result
// beat is registered when the lookup state commits, and a new access is
// taken only after the previous access has committed.
// After reset the block sweeps the valid and stamp memories, one set per
// cycle across all 2**LOG_MAX_SETS sets, with o_in_stall high; configuration
// writes over the APB port are taken at any time and reset to their defaults.
// When the receiver stalls, the result beat holds in the output register;
// one further access may be accepted and waits in its lookup cycle until
// the output register is free.
module set_assoc_lru_cache_tag_model_top
    import salc_pkg::*;
#(
    parameter int LOG_MAX_SETS = P_LOG_MAX_SETS,
    parameter int MAX_WAYS     = P_MAX_WAYS,
    parameter int COUNT_WIDTH  = P_COUNT_WIDTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in         i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out        o_out_data,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam logic [2:0] REG_INDEX_MODE = 3'd0;
    localparam logic [2:0] REG_LOG_ROWS   = 3'd1;
    localparam logic [2:0] REG_LOG_BLOCK  = 3'd2;
    localparam logic [2:0] REG_WAYS       = 3'd3;
    localparam logic [2:0] REG_LOG_PAGE   = 3'd4;
    localparam logic [2:0] REG_LOG_PHYS   = 3'd5;

    t_cfg r_cfg;
    t_cmd cmd;
    t_sts sts;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.index_mode   <= 2'd0;
            r_cfg.log_rows     <= 4'd10;
            r_cfg.log_block    <= 4'd5;
            r_cfg.ways_in_use  <= 4'd2;
            r_cfg.log_page     <= 5'd12;
            r_cfg.log_phys_mem <= 6'd28;
        end else if (psel && penable && pwrite) begin
            unique case (paddr[4:2])
                REG_INDEX_MODE: r_cfg.index_mode   <= pwdata[1:0];
                REG_LOG_ROWS:   r_cfg.log_rows     <= pwdata[3:0];
                REG_LOG_BLOCK:  r_cfg.log_block    <= pwdata[3:0];
                REG_WAYS:       r_cfg.ways_in_use  <= pwdata[3:0];
                REG_LOG_PAGE:   r_cfg.log_page     <= pwdata[4:0];
                REG_LOG_PHYS:   r_cfg.log_phys_mem <= pwdata[5:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (paddr[4:2])
            REG_INDEX_MODE: prdata = 32'(r_cfg.index_mode);
            REG_LOG_ROWS:   prdata = 32'(r_cfg.log_rows);
            REG_LOG_BLOCK:  prdata = 32'(r_cfg.log_block);
            REG_WAYS:       prdata = 32'(r_cfg.ways_in_use);
            REG_LOG_PAGE:   prdata = 32'(r_cfg.log_page);
            REG_LOG_PHYS:   prdata = 32'(r_cfg.log_phys_mem);
            default:        prdata = '0;
        endcase
    end

    salc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_sts      (sts),
        .o_in_stall (o_in_stall),
        .o_cmd      (cmd)
    );

    salc_dp #(
        .LOG_MAX_SETS (LOG_MAX_SETS),
        .MAX_WAYS     (MAX_WAYS),
        .COUNT_WIDTH  (COUNT_WIDTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_cfg       (r_cfg),
        .i_in_data   (i_in_data),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule
